### sv/assert_macros.svh
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define DQ_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("deque assertion failed");

// Check that a condition in one cycle implies another in the next.
`define DQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque assertion failed");

`endif

### sv/dq_pkg.sv
// Types and constants shared by the deque modules.
package dq_pkg;

  localparam int DQ_CAPACITY = 16;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    FUNC_PUSH_FRONT = 2'd0,
    FUNC_PUSH_BACK  = 2'd1,
    FUNC_POP_FRONT  = 2'd2,
    FUNC_POP_BACK   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_READ,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture the request
    logic update;  // apply the operation to head, count and store
    logic read;    // fetch front and back entries
  } dq_cmd_t;

endpackage

### sv/dq_ctrl.sv
// Controller state machine that sequences one request through the datapath.
module dq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  output logic            done,
  output dq_pkg::dq_cmd_t cmd
);
  import dq_pkg::*;

  state_t state;
  state_t state_next;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance through update, read and done for each request
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### sv/dq_datapath.sv
// Deque datapath: circular store, head index, fill count and result registers.
module dq_datapath #(
  parameter int CAPACITY = dq_pkg::DQ_CAPACITY,
  parameter int IDX_W    = $clog2(CAPACITY),
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  dq_pkg::dq_cmd_t            cmd,
  input  logic [1:0]                 func,
  input  logic signed [dq_pkg::DATA_W-1:0] value,
  output logic signed [dq_pkg::DATA_W-1:0] front_value,
  output logic signed [dq_pkg::DATA_W-1:0] back_value,
  output logic [CNT_W-1:0]           count,
  output logic                       is_empty,
  output logic [1:0]                 status
);
  import dq_pkg::*;

  localparam int SUM_W = CNT_W + 1;

  logic signed [DATA_W-1:0] mem [CAPACITY];

  logic [1:0]               op;
  logic signed [DATA_W-1:0] val;
  logic [IDX_W-1:0]         head;
  logic [IDX_W-1:0]         head_next;
  logic [CNT_W-1:0]         fill;
  logic [CNT_W-1:0]         fill_next;
  stat_t                    stat;
  stat_t                    stat_next;
  logic signed [DATA_W-1:0] rd_front;
  logic signed [DATA_W-1:0] rd_back;

  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr;
  logic [SUM_W-1:0]         tail_sum;
  logic [IDX_W-1:0]         tail_idx;
  logic [IDX_W-1:0]         back_idx;
  logic [IDX_W-1:0]         head_inc;
  logic [IDX_W-1:0]         head_dec;
  logic                     full;
  logic                     empty;

  // Wrap the index arithmetic around the store
  always_comb begin
    tail_sum = SUM_W'(head) + SUM_W'(fill);
    if (tail_sum >= SUM_W'(CAPACITY)) begin
      tail_idx = IDX_W'(tail_sum - SUM_W'(CAPACITY));
    end else begin
      tail_idx = IDX_W'(tail_sum);
    end
    back_idx = (tail_idx == '0) ? IDX_W'(CAPACITY - 1) : tail_idx - 1'b1;
    head_inc = (head == IDX_W'(CAPACITY - 1)) ? '0 : head + 1'b1;
    head_dec = (head == '0) ? IDX_W'(CAPACITY - 1) : head - 1'b1;
    full     = (fill == CNT_W'(CAPACITY));
    empty    = (fill == '0);
  end

  // Work out the effect of the captured request
  always_comb begin
    head_next = head;
    fill_next = fill;
    stat_next = STAT_OK;
    wr_en     = 1'b0;
    wr_addr   = tail_idx;
    case (op)
      FUNC_PUSH_FRONT: begin
        if (full) begin
          stat_next = STAT_FULL;
        end else begin
          head_next = head_dec;
          wr_en     = 1'b1;
          wr_addr   = head_dec;
          fill_next = fill + 1'b1;
        end
      end
      FUNC_PUSH_BACK: begin
        if (full) begin
          stat_next = STAT_FULL;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = tail_idx;
          fill_next = fill + 1'b1;
        end
      end
      FUNC_POP_FRONT: begin
        if (empty) begin
          stat_next = STAT_EMPTY;
        end else begin
          head_next = head_inc;
          fill_next = fill - 1'b1;
        end
      end
      FUNC_POP_BACK: begin
        if (empty) begin
          stat_next = STAT_EMPTY;
        end else begin
          fill_next = fill - 1'b1;
        end
      end
      default: begin
        stat_next = STAT_OK;
      end
    endcase
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= func;
      val <= value;
    end
  end

  // Update head and count
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else if (cmd.update) begin
      head <= head_next;
      fill <= fill_next;
    end
  end

  // Record the status of the request
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      stat <= stat_next;
    end
  end

  // Write a pushed value into the store
  always_ff @(posedge clk) begin
    if (cmd.update && wr_en) begin
      mem[wr_addr] <= val;
    end
  end

  // Read front and back entries after the update
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_front <= mem[head];
      rd_back  <= mem[back_idx];
    end
  end

  // Drive the result; an empty queue shows zero values
  assign front_value = empty ? '0 : rd_front;
  assign back_value  = empty ? '0 : rd_back;
  assign count       = fill;
  assign is_empty    = empty;
  assign status      = stat;

endmodule

### sv/double_ended_queue.sv
// Bounded double-ended queue top level: controller plus datapath.
// After the accepting edge the controller steps through update, read and done; the result is shown while done is high.
// Busy stays high until done, so a new request is taken only once the last one is through.
// The store has one write port and two registered read ports for front and back.
// Synchronous reset empties the queue (head and count to zero); the store is not cleared.
module double_ended_queue #(
  parameter int CAPACITY = dq_pkg::DQ_CAPACITY,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       func,
  input  logic signed [dq_pkg::DATA_W-1:0] value,
  output logic                             done,
  output logic signed [dq_pkg::DATA_W-1:0] front_value,
  output logic signed [dq_pkg::DATA_W-1:0] back_value,
  output logic [CNT_W-1:0]                 count,
  output logic                             is_empty,
  output logic [1:0]                       status
);
  import dq_pkg::*;

  dq_cmd_t cmd;

  dq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  dq_datapath #(
    .CAPACITY (CAPACITY),
    .IDX_W    ($clog2(CAPACITY)),
    .CNT_W    (CNT_W)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .func        (func),
    .value       (value),
    .front_value (front_value),
    .back_value  (back_value),
    .count       (count),
    .is_empty    (is_empty),
    .status      (status)
  );

endmodule

### sv/dq_checker.sv
// Port-level checker for the deque, bound to the top level.
`include "assert_macros.svh"

module dq_checker #(
  parameter int CAPACITY = dq_pkg::DQ_CAPACITY,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             start,
  input logic                             busy,
  input logic                             done,
  input logic signed [dq_pkg::DATA_W-1:0] front_value,
  input logic signed [dq_pkg::DATA_W-1:0] back_value,
  input logic [CNT_W-1:0]                 count,
  input logic                             is_empty,
  input logic [1:0]                       status
);
  import dq_pkg::*;

  // An accepted request keeps the block busy in the next cycle
  `DQ_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)

  // The empty flag agrees with the count
  `DQ_ASSERT(a_empty_count, clk, rst, !done || (is_empty == (count == '0)))

  // An empty queue shows zero front and back values
  `DQ_ASSERT(a_empty_zero, clk, rst, !(done && is_empty) || (front_value == '0 && back_value == '0))

  // A rejected push only happens on a full queue
  `DQ_ASSERT(a_full_reject, clk, rst, !(done && status == STAT_FULL) || (count == CNT_W'(CAPACITY)))

  // A rejected pop only happens on an empty queue
  `DQ_ASSERT(a_empty_reject, clk, rst, !(done && status == STAT_EMPTY) || is_empty)

endmodule

bind double_ended_queue dq_checker #(
  .CAPACITY (CAPACITY),
  .CNT_W    (CNT_W)
) u_dq_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .front_value (front_value),
  .back_value  (back_value),
  .count       (count),
  .is_empty    (is_empty),
  .status      (status)
);

### tb/deque_tb_pkg.sv
// Deque state tracker: predicts each result and checks the block's results against it.
package deque_tb_pkg;

  import dq_pkg::*;

  typedef struct {
    logic signed [DATA_W-1:0] front;
    logic signed [DATA_W-1:0] back;
    logic [4:0]               count;
    logic                     empty;
    stat_t                    status;
  } deque_result_t;

  class deque_tracker;
    logic signed [DATA_W-1:0] entries [DQ_CAPACITY];
    logic [3:0]               head;
    logic [4:0]               fill;
    deque_result_t            pending_results [$];
    int                       errors;

    function new();
      head   = '0;
      fill   = '0;
      errors = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Apply one accepted request to the tracked deque and queue its result.
    function void note_request(func_t op, logic signed [DATA_W-1:0] val);
      deque_result_t res;
      logic [3:0]    idx;
      res.status = STAT_OK;
      case (op)
        FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
          if (fill == DQ_CAPACITY) begin
            res.status = STAT_FULL;
          end else if (op == FUNC_PUSH_FRONT) begin
            head          = head - 4'd1;
            entries[head] = val;
            fill          = fill + 5'd1;
          end else begin
            idx          = head + fill[3:0];
            entries[idx] = val;
            fill         = fill + 5'd1;
          end
        end
        default: begin
          if (fill == 0) begin
            res.status = STAT_EMPTY;
          end else begin
            if (op == FUNC_POP_FRONT) head = head + 4'd1;
            fill = fill - 5'd1;
          end
        end
      endcase
      // Report zero values when nothing is stored
      if (fill == 0) begin
        res.front = '0;
        res.back  = '0;
      end else begin
        idx       = head + fill[3:0] - 4'd1;
        res.front = entries[head];
        res.back  = entries[idx];
      end
      res.count = fill;
      res.empty = (fill == 0);
      pending_results = {pending_results, res};
    endfunction

    // Compare one result strobe with the oldest prediction.
    function void check_result(logic signed [DATA_W-1:0] front, logic signed [DATA_W-1:0] back,
                               logic [4:0] count, logic empty, logic [1:0] status);
      deque_result_t exp_res;
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request outstanding: front %0d back %0d count %0d",
                 $time, front, back, count);
        errors++;
        return;
      end
      exp_res = pending_results[0];
      pending_results.delete(0);
      if (front !== exp_res.front) begin
        $display("%0t: front_value expected %0d actual %0d", $time, exp_res.front, front);
        errors++;
      end
      if (back !== exp_res.back) begin
        $display("%0t: back_value expected %0d actual %0d", $time, exp_res.back, back);
        errors++;
      end
      if (count !== exp_res.count) begin
        $display("%0t: count expected %0d actual %0d", $time, exp_res.count, count);
        errors++;
      end
      if (empty !== exp_res.empty) begin
        $display("%0t: is_empty expected %0b actual %0b", $time, exp_res.empty, empty);
        errors++;
      end
      if (status !== exp_res.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_res.status, status);
        errors++;
      end
    endfunction
  endclass

endpackage

### tb/tb_top.sv
// Top-level testbench for the double-ended queue: clock, reset, request driver and monitor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dq_pkg::*;
  import deque_tb_pkg::*;

  localparam int RANDOM_REQUESTS = 1025;

  logic                     clk   = 1'b0;
  logic                     rst   = 1'b1;
  logic                     start = 1'b0;
  logic [1:0]               func  = FUNC_PUSH_FRONT;
  logic signed [DATA_W-1:0] value = '0;
  logic                     busy;
  logic                     done;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] back_value;
  logic [4:0]               count;
  logic                     is_empty;
  logic [1:0]               status;

  deque_tracker tracker = new();

  double_ended_queue DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .value       (value),
    .done        (done),
    .front_value (front_value),
    .back_value  (back_value),
    .count       (count),
    .is_empty    (is_empty),
    .status      (status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Check results, then record newly accepted requests
  always @(posedge clk) begin
    if (!rst && done) tracker.check_result(front_value, back_value, count, is_empty, status);
    if (!rst && start && !busy) tracker.note_request(func_t'(func), value);
  end

  // Hold the request until the block takes it
  task automatic send_request(func_t op, logic signed [DATA_W-1:0] val);
    start <= 1'b1;
    func  <= op;
    value <= val;
    do @(posedge clk); while (busy);
  endtask

  // Drop start for a few cycles
  task automatic idle_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off until every outstanding request has returned its result
  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk);
    while (tracker.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] push_value();
    case ($urandom_range(15))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    #200000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int    burst_left;
    int    push_pct;
    bit    idle_on;
    func_t op;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty pops, extreme values, fill to full, pushes on full, pops from a full queue
    send_request(FUNC_POP_FRONT, 32'h7fff_ffff);
    send_request(FUNC_POP_BACK, 32'h8000_0000);
    send_request(FUNC_PUSH_FRONT, 32'h8000_0000);
    send_request(FUNC_PUSH_BACK, 32'h7fff_ffff);
    send_request(FUNC_POP_FRONT, $urandom);
    send_request(FUNC_POP_BACK, $urandom);
    send_request(FUNC_PUSH_BACK, '1);
    send_request(FUNC_PUSH_FRONT, '0);
    for (int i = 0; i < DQ_CAPACITY - 2; i++) begin
      send_request((i % 2) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT, push_value());
    end
    send_request(FUNC_PUSH_FRONT, 32'h1234_5678);
    send_request(FUNC_PUSH_BACK, 32'h8765_4321);
    send_request(FUNC_POP_FRONT, '1);
    send_request(FUNC_POP_BACK, '0);

    // Random walk in bursts that lean toward pushes, toward pops or neither, with idle gaps and drain points
    burst_left = 0;
    push_pct   = 50;
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(40, 8);
        case ($urandom_range(2))
          0:       push_pct = 85;
          1:       push_pct = 15;
          default: push_pct = 50;
        endcase
      end
      burst_left--;
      if (i == 200 || i == 800) wait_drained();
      idle_on = (i < 400 || i >= 700);
      if (idle_on && $urandom_range(99) < 6) idle_sender($urandom_range(4, 1));
      if ($urandom_range(99) < push_pct) begin
        op = $urandom_range(1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
        send_request(op, push_value());
      end else begin
        op = $urandom_range(1) ? FUNC_POP_BACK : FUNC_POP_FRONT;
        send_request(op, $urandom);
      end
    end

    // Drain and give the block time to show any stray result
    wait_drained();
    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
